>>> src/smaf_pkg.sv
// shared constants and types for the sliding median filter
package smaf_pkg;

    localparam int MAX_WINDOW = 32;
    localparam int SLOT_W     = $clog2(MAX_WINDOW);
    localparam int LEN_W      = SLOT_W + 1;
    localparam int VAL_W      = 16;
    localparam int SAMPLE_W   = 16;

    localparam logic [LEN_W-1:0] WINDOW_RESET = LEN_W'(5);

    // one entry of the sorted list: magnitude and the ring slot it came from
    typedef struct packed {
        logic [VAL_W-1:0]  val;
        logic [SLOT_W-1:0] tag;
    } entry_t;

endpackage

>>> src/sliding_median_abs_filter_unit.sv
// sliding median of absolute values over a configurable window
//
// The block keeps the magnitudes of the last 32 samples as a list sorted in
// ascending order, each entry tagged with the ring slot it was written to.
// A sample beat replaces the oldest entry: one merge pass streams the sorted
// list from one bank of a 64-entry memory into the other, dropping the
// entry whose tag is the slot being overwritten and inserting the new
// magnitude in order. The single shared magnitude compare decides each step.
// While the list streams past, entries whose age is below window_len are
// counted, and the one at count window_len/2 is the median; for an even
// window this is the upper middle value. After reset the block runs a
// clearing pass that fills the list with zeros tagged 0..31, and
// sample_stall stays high meanwhile (configuration writes are taken as ever).
// An item passes from acceptance to a result in the output register
// through one merge step per list entry plus at most one skipped entry,
// then the hand-over to the output, all set by the one read and one
// write port of the list memory. The hand-over waits for as long as the
// previous result is still stalled in the output register. A result waits
// in its output register while the next sample is taken. window_len 0 acts
// as 1 and values above 32 as 32; a new length takes effect at once over
// the stored history.
module sliding_median_abs_filter_unit
    import smaf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    // sample channel
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       sample_valid,
    output logic                       sample_stall,
    // result channel
    output logic        [VAL_W-1:0]    median_abs,
    output logic                       median_abs_valid,
    input  logic                       median_abs_stall,
    // window length register
    input  logic        [LEN_W-1:0]    cfg_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready
);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_MERGE  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_WINDOW - 1);
    localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(MAX_WINDOW);

    // control state
    logic [1:0]        state_reg, state_next;
    logic              bank_reg, bank_next;
    logic [LEN_W-1:0]  r_reg, r_next;
    logic [SLOT_W-1:0] w_reg, w_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic              inserted_reg, inserted_next;
    logic [SLOT_W-1:0] oldest_slot_reg, oldest_slot_next;
    logic [LEN_W-1:0]  window_len_reg;
    logic              out_valid_reg, out_valid_next;

    // payload held for the current beat
    logic [LEN_W-1:0]  n_reg, n_next;
    logic [SLOT_W-1:0] ins_slot_reg, ins_slot_next;
    logic [VAL_W-1:0]  new_val_reg, new_val_next;
    logic [VAL_W-1:0]  sel_reg, sel_next;
    logic [VAL_W-1:0]  median_abs_reg, median_abs_next;

    // sorted list memory, two banks
    entry_t            list_mem [2*MAX_WINDOW];
    entry_t            rd_data_reg;
    logic [SLOT_W:0]   rd_addr;
    logic [SLOT_W:0]   wr_addr;
    entry_t            wr_data;
    logic              wr_en;

    logic              in_accept;
    logic [LEN_W-1:0]  n_eff;
    logic [VAL_W-1:0]  mag;
    logic              head_valid;
    logic              skip;
    logic              take_new;
    logic              take_head;
    logic              emit;
    entry_t            emit_entry;
    logic [SLOT_W-1:0] age;
    logic              in_win;

    assign sample_stall     = (state_reg != ST_IDLE);
    assign in_accept        = sample_valid && !sample_stall;
    assign cfg_ready        = 1'b1;
    assign median_abs       = median_abs_reg;
    assign median_abs_valid = out_valid_reg;

    // clamp the window to 1..32
    always_comb
    begin
        if (window_len_reg == '0)
        begin
            n_eff = LEN_W'(1);
        end
        else if (window_len_reg > MAX_LEN)
        begin
            n_eff = MAX_LEN;
        end
        else
        begin
            n_eff = window_len_reg;
        end
    end

    // magnitude, most negative sample maps to 32768
    assign mag = sample[SAMPLE_W-1] ? VAL_W'(-sample) : VAL_W'(sample);

    // merge step decision
    always_comb
    begin
        head_valid = !r_reg[LEN_W-1];
        skip       = (state_reg == ST_MERGE) && head_valid
                     && (rd_data_reg.tag == ins_slot_reg);
        take_new   = (state_reg == ST_MERGE) && !skip && !inserted_reg
                     && (!head_valid || (new_val_reg <= rd_data_reg.val));
        take_head  = (state_reg == ST_MERGE) && !skip && !take_new && head_valid;
        emit       = take_new || take_head;
        if (take_new)
        begin
            emit_entry.val = new_val_reg;
            emit_entry.tag = ins_slot_reg;
        end
        else
        begin
            emit_entry = rd_data_reg;
        end
        // age relative to the newest slot, wraps round the ring
        age    = ins_slot_reg - emit_entry.tag;
        in_win = ({1'b0, age} < n_reg);
        r_next = r_reg + ((skip || take_head) ? LEN_W'(1) : LEN_W'(0));
    end

    // memory port addressing
    always_comb
    begin
        if (state_reg == ST_MERGE)
        begin
            rd_addr = {bank_reg, r_next[SLOT_W-1:0]};
        end
        else
        begin
            rd_addr = {bank_reg, {SLOT_W{1'b0}}};
        end

        if (state_reg == ST_CLEAR)
        begin
            wr_en       = 1'b1;
            wr_addr     = {1'b0, w_reg};
            wr_data.val = '0;
            wr_data.tag = w_reg;
        end
        else
        begin
            wr_en   = emit;
            wr_addr = {!bank_reg, w_reg};
            wr_data = emit_entry;
        end
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        bank_next        = bank_reg;
        w_next           = w_reg;
        cnt_next         = cnt_reg;
        inserted_next    = inserted_reg;
        oldest_slot_next = oldest_slot_reg;
        out_valid_next   = out_valid_reg;
        n_next           = n_reg;
        ins_slot_next    = ins_slot_reg;
        new_val_next     = new_val_reg;
        sel_next         = sel_reg;
        median_abs_next  = median_abs_reg;

        // result taken downstream
        if (out_valid_reg && !median_abs_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                w_next = w_reg + SLOT_W'(1);
                if (w_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next       = ST_MERGE;
                    w_next           = '0;
                    cnt_next         = '0;
                    inserted_next    = 1'b0;
                    n_next           = n_eff;
                    ins_slot_next    = oldest_slot_reg;
                    new_val_next     = mag;
                    oldest_slot_next = oldest_slot_reg + SLOT_W'(1);
                end
            end
            ST_MERGE:
            begin
                if (take_new)
                begin
                    inserted_next = 1'b1;
                end
                if (emit)
                begin
                    w_next = w_reg + SLOT_W'(1);
                    if (in_win)
                    begin
                        cnt_next = cnt_reg + LEN_W'(1);
                        if (cnt_reg == {1'b0, n_reg[LEN_W-1:1]})
                        begin
                            sel_next = emit_entry.val;
                        end
                    end
                    if (w_reg == LAST_SLOT)
                    begin
                        bank_next  = !bank_reg;
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !median_abs_stall)
                begin
                    out_valid_next  = 1'b1;
                    median_abs_next = sel_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            bank_reg        <= 1'b0;
            r_reg           <= '0;
            w_reg           <= '0;
            cnt_reg         <= '0;
            inserted_reg    <= 1'b0;
            oldest_slot_reg <= '0;
            window_len_reg  <= WINDOW_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            bank_reg        <= bank_next;
            r_reg           <= in_accept ? '0 : r_next;
            w_reg           <= w_next;
            cnt_reg         <= cnt_next;
            inserted_reg    <= inserted_next;
            oldest_slot_reg <= oldest_slot_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                window_len_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        ins_slot_reg   <= ins_slot_next;
        new_val_reg    <= new_val_next;
        sel_reg        <= sel_next;
        median_abs_reg <= median_abs_next;
    end

    // sorted list memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            list_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= list_mem[rd_addr];
    end

    // read pointer runs at most one entry ahead of or behind the write pointer
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MERGE) |-> (r_reg <= ({1'b0, w_reg} + LEN_W'(1))))
        else $error("read pointer too far ahead of write pointer");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MERGE) |-> ((r_reg + LEN_W'(1)) >= {1'b0, w_reg}))
        else $error("write pointer too far ahead of read pointer");

    // every slot of the window was seen exactly once in the merge
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> (cnt_reg == n_reg))
        else $error("window count differs from window length");

    // the new magnitude was placed in the list
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> inserted_reg)
        else $error("merge ended without inserting the new value");

endmodule

>>> tb/tb_sliding_median_abs_filter_unit.sv
// self-checking testbench for the sliding median of absolute values unit
`timescale 1ns / 1ps

module tb_sliding_median_abs_filter_unit;
    import smaf_pkg::*;

    // kinds of row in the directed stimulus table
    typedef enum logic
    {
        ROW_CFG,
        ROW_SAMPLE
    } row_kind_t;

    // one directed row: a window length write or a sample beat, with an
    // optional hand-typed median where it is obvious from the window
    typedef struct packed
    {
        row_kind_t        kind;
        logic [VAL_W-1:0] value;
        logic             typed;
        logic [VAL_W-1:0] median;
    } stim_row_t;

    localparam int SEGMENTS     = 12;
    localparam int SEG_ITEMS    = 100;
    localparam int SETTLE_BEATS = 40;

    // window lengths at and beyond the legal range
    localparam logic [LEN_W-1:0] LEN_ZERO = LEN_W'(0);
    localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_WINDOW);
    localparam logic [LEN_W-1:0] LEN_OVER = LEN_W'(MAX_WINDOW + 1);
    localparam logic [LEN_W-1:0] LEN_TOP  = {LEN_W{1'b1}};

    logic                       clk;
    logic                       rst_n;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sample_valid;
    logic                       sample_stall;
    logic        [VAL_W-1:0]    median_abs;
    logic                       median_abs_valid;
    logic                       median_abs_stall = 1'b0;
    logic        [LEN_W-1:0]    cfg_data;
    logic                       cfg_valid;
    logic                       cfg_ready;

    // predictor copy of the block state
    logic [VAL_W-1:0]  mag_ring [MAX_WINDOW];
    logic [SLOT_W-1:0] write_slot;
    logic [LEN_W-1:0]  window_reg;

    // medians still owed by the block, oldest first
    logic [VAL_W-1:0]  pending_medians [$];
    stim_row_t         stim_table [$];

    int send_idle_pct;
    int recv_stall_pct;
    int errors;
    int n_samples;
    int n_medians;
    int n_cfg;
    logic [VAL_W-1:0]  want_median;
    logic [VAL_W-1:0]  last_sample;

    sliding_median_abs_filter_unit uut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .sample           (sample),
        .sample_valid     (sample_valid),
        .sample_stall     (sample_stall),
        .median_abs       (median_abs),
        .median_abs_valid (median_abs_valid),
        .median_abs_stall (median_abs_stall),
        .cfg_data         (cfg_data),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #5_000_000;
        $display("%0t: timeout, %0d medians still owed", $time, pending_medians.size());
        $display("Some tests failed");
        $finish;
    end

    function automatic stim_row_t mk_row(row_kind_t kind, logic [VAL_W-1:0] value,
                                         logic typed, logic [VAL_W-1:0] median);
        stim_row_t r;
        r.kind   = kind;
        r.value  = value;
        r.typed  = typed;
        r.median = median;
        return r;
    endfunction

    // store the new magnitude in the ring, then sort the newest n values
    // and take the one at position n/2 (upper middle for an even window)
    function automatic logic [VAL_W-1:0] median_after(logic [SAMPLE_W-1:0] s);
        logic [VAL_W-1:0]  win [MAX_WINDOW];
        logic [VAL_W-1:0]  v;
        logic [SLOT_W-1:0] idx;
        int                n;
        int                k;
        n = int'(window_reg);
        if (n < 1)
            n = 1;
        if (n > MAX_WINDOW)
            n = MAX_WINDOW;
        // -32768 wraps to 16'h8000, which reads as 32768 unsigned
        mag_ring[write_slot] = s[SAMPLE_W-1] ? (~s + 1'b1) : s;
        write_slot = write_slot + 1'b1;
        for (int j = 0; j < n; j++)
        begin
            idx = write_slot - 1'b1 - SLOT_W'(j);
            v = mag_ring[idx];
            k = j;
            while (k > 0 && win[k-1] > v)
            begin
                win[k] = win[k-1];
                k--;
            end
            win[k] = v;
        end
        return win[n/2];
    endfunction

    // one sample beat, with random idle cycles in front; valid stays high
    // on return so back-to-back beats never drop it within a step
    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic typed,
                               input logic [VAL_W-1:0] typed_median);
        logic [VAL_W-1:0] predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            sample       <= SAMPLE_W'($urandom);
            @(posedge clk);
        end
        sample       <= value;
        sample_valid <= 1'b1;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        predicted = median_after(value);
        pending_medians.push_back(typed ? typed_median : predicted);
        n_samples++;
    endtask

    // window length write, only once every owed median has come out
    task automatic write_window(input logic [LEN_W-1:0] len);
        sample_valid <= 1'b0;
        while (pending_medians.size() != 0)
            @(posedge clk);
        cfg_data  <= len;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        window_reg  = len;
        n_cfg++;
    endtask

    // receiver back-pressure, independent of the result valid
    always @(posedge clk)
        median_abs_stall <= ($urandom_range(99) < recv_stall_pct);

    // result checker: each median beat against the oldest owed value
    always @(posedge clk)
    begin
        if (rst_n && median_abs_valid && !median_abs_stall)
        begin
            if (pending_medians.size() == 0)
            begin
                $display("%0t: median beat with nothing owed, expected none, actual %0d",
                         $time, median_abs);
                errors++;
            end
            else
            begin
                want_median = pending_medians.pop_front();
                n_medians++;
                if (median_abs !== want_median)
                begin
                    $display("%0t: median_abs mismatch, expected %0d, actual %0d",
                             $time, want_median, median_abs);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t        row;
        logic [LEN_W-1:0] len;
        logic [VAL_W-1:0] s;

        // every input known from time zero
        rst_n         = 1'b0;
        sample        = '0;
        sample_valid  = 1'b0;
        cfg_data      = '0;
        cfg_valid     = 1'b0;
        send_idle_pct = 6;
        recv_stall_pct = 63;
        errors        = 0;
        n_samples     = 0;
        n_medians     = 0;
        n_cfg         = 0;
        last_sample   = '0;
        window_reg    = WINDOW_RESET;
        write_slot    = '0;
        for (int j = 0; j < MAX_WINDOW; j++)
            mag_ring[j] = '0;

        // directed rows: reset window of five over a cleared history first
        stim_table.push_back(mk_row(ROW_SAMPLE, 16'd1000, 1'b1, 16'd0));
        stim_table.push_back(mk_row(ROW_SAMPLE, 16'h8000, 1'b0, 16'd0));
        stim_table.push_back(mk_row(ROW_SAMPLE, 16'h7FFF, 1'b0, 16'd0));
        stim_table.push_back(mk_row(ROW_SAMPLE, 16'hFFFF, 1'b0, 16'd0));
        stim_table.push_back(mk_row(ROW_SAMPLE, 16'd0,    1'b0, 16'd0));
        // window of one passes magnitudes straight through, extremes included
        stim_table.push_back(mk_row(ROW_CFG,    VAL_W'(LEN_ONE), 1'b0, 16'd0));
        stim_table.push_back(mk_row(ROW_SAMPLE, 16'h8000, 1'b1, 16'd32768));
        stim_table.push_back(mk_row(ROW_SAMPLE, 16'h7FFF, 1'b1, 16'd32767));
        stim_table.push_back(mk_row(ROW_SAMPLE, 16'hFFFF, 1'b1, 16'd1));
        stim_table.push_back(mk_row(ROW_SAMPLE, 16'd0,    1'b1, 16'd0));
        // zero length behaves as one
        stim_table.push_back(mk_row(ROW_CFG,    VAL_W'(LEN_ZERO), 1'b0, 16'd0));
        stim_table.push_back(mk_row(ROW_SAMPLE, 16'hFFFB, 1'b1, 16'd5));
        stim_table.push_back(mk_row(ROW_SAMPLE, 16'd1,    1'b1, 16'd1));
        // even window picks the upper middle
        stim_table.push_back(mk_row(ROW_CFG,    16'd2,    1'b0, 16'd0));
        stim_table.push_back(mk_row(ROW_SAMPLE, 16'd7,    1'b1, 16'd7));
        stim_table.push_back(mk_row(ROW_SAMPLE, 16'd3,    1'b1, 16'd7));
        // full window, then lengths past the maximum clamp to it
        stim_table.push_back(mk_row(ROW_CFG,    VAL_W'(LEN_FULL), 1'b0, 16'd0));
        stim_table.push_back(mk_row(ROW_SAMPLE, 16'd100,  1'b0, 16'd0));
        stim_table.push_back(mk_row(ROW_CFG,    VAL_W'(LEN_OVER), 1'b0, 16'd0));
        stim_table.push_back(mk_row(ROW_SAMPLE, 16'hFF38, 1'b0, 16'd0));
        stim_table.push_back(mk_row(ROW_CFG,    VAL_W'(LEN_TOP),  1'b0, 16'd0));
        stim_table.push_back(mk_row(ROW_SAMPLE, 16'd300,  1'b0, 16'd0));
        // shorter window over the stored history takes effect at once
        stim_table.push_back(mk_row(ROW_CFG,    16'd4,    1'b0, 16'd0));
        stim_table.push_back(mk_row(ROW_SAMPLE, 16'd12345, 1'b0, 16'd0));
        stim_table.push_back(mk_row(ROW_SAMPLE, 16'hCFC7, 1'b0, 16'd0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, run while the clearing pass may still hold stall
        foreach (stim_table[i])
        begin
            row = stim_table[i];
            if (row.kind == ROW_CFG)
                write_window(row.value[LEN_W-1:0]);
            else
                send_sample(row.value, row.typed, row.median);
        end

        // random part: three idling phases, a new window per segment
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg / (SEGMENTS / 3))
                0:
                begin
                    send_idle_pct  = 6;
                    recv_stall_pct = 63;
                end
                1:
                begin
                    send_idle_pct  = 63;
                    recv_stall_pct = 6;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase

            // mostly legal lengths, now and then the edge values
            case ($urandom_range(7))
                0:       len = LEN_ZERO;
                1:       len = LEN_TOP;
                2:       len = ($urandom_range(1) != 0) ? LEN_FULL : LEN_OVER;
                3:       len = LEN_ONE;
                default: len = LEN_W'($urandom_range(1, MAX_WINDOW));
            endcase
            write_window(len);

            for (int k = 0; k < SEG_ITEMS; k++)
            begin
                // mix of extremes, small values and repeats to force ties
                case ($urandom_range(9))
                    0:       s = 16'h8000;
                    1:       s = 16'h7FFF;
                    2, 3:    s = VAL_W'($urandom_range(16)) - 16'd8;
                    4:       s = last_sample;
                    5:       s = ~last_sample + 1'b1;
                    default: s = VAL_W'($urandom);
                endcase
                last_sample = s;
                send_sample(s, 1'b0, 16'd0);
            end
        end

        // drain, then give the block time to show any stray beat
        sample_valid <= 1'b0;
        while (pending_medians.size() != 0)
            @(posedge clk);
        repeat (SETTLE_BEATS) @(posedge clk);

        $display("covered %0d sample beats, %0d median beats, %0d window writes",
                 n_samples, n_medians, n_cfg);
        $display("windows from zero to %0d, under sender gaps and receiver stalls",
                 LEN_TOP);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
